@@ rtl/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, constants and byte classes for the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

	// Width of the internal Content-Length accumulator (default)
	localparam int LENGTH_BITS_DEF = 31;
	// Width of the content_length result field
	localparam int OUT_LEN_W       = 31;
	localparam int STATUS_W        = 16;
	localparam int LIMIT_W         = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

	// Characters of interest
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Last three bytes that, followed by LF, close the header
	localparam logic [23:0] HDR_END_TAIL = {CH_CR, CH_LF, CH_CR};

	// Length of the "Content-Length:" key
	localparam logic [3:0] KEY_LEN = 4'd15;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_TOKEN  = 3'd1,
		PH_GAP    = 3'd2,
		PH_DIGITS = 3'd3,
		PH_REST   = 3'd4,
		PH_HEADER = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		LP_NONE   = 2'd0,
		LP_SPACE  = 2'd1,
		LP_DIGITS = 2'd2,
		LP_DONE   = 2'd3
	} len_phase_t;

	typedef enum logic [1:0] {
		OUT_DONE     = 2'd0,
		OUT_CLOSED   = 2'd1,
		OUT_TOO_LONG = 2'd2
	} outcome_t;

	// One result as produced by the parse core
	typedef struct packed {
		logic                  emit;
		logic [STATUS_W-1:0]   status_code;
		logic [OUT_LEN_W-1:0]  content_length;
		logic                  length_known;
		outcome_t              outcome;
	} hrp_result_t;

	// Character of the key at a given position
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	// Space, tab, LF, VT, FF, CR
	function automatic logic is_white(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

endpackage

@@ rtl/hrp_parse_core.sv @@
// ----------------------------------------------------------------------------
// hrp_parse_core
// Running parse state of one response; updates on each beat taken from the
// input register and forms the result when the response ends.
// ----------------------------------------------------------------------------
module hrp_parse_core
	import hrp_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               beat_fire,
	input  logic [7:0]         data_byte_s1,
	input  logic               closed_s1,
	input  logic [LIMIT_W-1:0] limit,
	output hrp_result_t        result
);

	localparam int WIDE = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;

	phase_t                   phase_q,     phase_d;
	logic [23:0]              recent_q,    recent_d;
	logic [STATUS_W-1:0]      status_q,    status_d;
	logic [3:0]               match_q,     match_d;
	len_phase_t               lphase_q,    lphase_d;
	logic [LENGTH_BITS-1:0]   length_q,    length_d;
	logic [LIMIT_W-1:0]       seen_q,      seen_d;

	logic [7:0]               b;
	logic [3:0]               digit;
	logic [STATUS_W+3:0]      status_x10;
	logic [STATUS_W-1:0]      status_next;
	logic [LENGTH_BITS+3:0]   length_x10;
	logic [LENGTH_BITS-1:0]   length_next;
	logic [WIDE-1:0]          acc_wide;
	logic [WIDE-1:0]          max_wide;
	logic [OUT_LEN_W-1:0]     len_out;

	assign b     = data_byte_s1;
	assign digit = 4'(b - CH_ZERO);

	// Decimal accumulate with saturation
	always_comb begin
		status_x10 = ({4'b0, status_q} << 3) + ({4'b0, status_q} << 1)
			+ (STATUS_W+4)'(digit);
		status_next = (status_x10 > (STATUS_W+4)'({STATUS_W{1'b1}}))
			? {STATUS_W{1'b1}} : status_x10[STATUS_W-1:0];
		length_x10 = ({4'b0, length_q} << 3) + ({4'b0, length_q} << 1)
			+ (LENGTH_BITS+4)'(digit);
		length_next = (length_x10 > (LENGTH_BITS+4)'({LENGTH_BITS{1'b1}}))
			? {LENGTH_BITS{1'b1}} : length_x10[LENGTH_BITS-1:0];
	end

	// Clamp the accumulator to the result field
	always_comb begin
		acc_wide = WIDE'(length_q);
		max_wide = WIDE'({OUT_LEN_W{1'b1}});
		len_out  = (acc_wide > max_wide) ? OUT_LEN_W'(max_wide) : OUT_LEN_W'(acc_wide);
	end

	// Next state and result for the beat in the input register
	always_comb begin
		phase_d  = phase_q;
		recent_d = recent_q;
		status_d = status_q;
		match_d  = match_q;
		lphase_d = lphase_q;
		length_d = length_q;
		seen_d   = seen_q;

		result.emit           = 1'b0;
		result.outcome        = OUT_DONE;
		result.status_code    = (phase_q == PH_HEADER) ? status_q : '0;
		result.content_length = '0;
		result.length_known   = 1'b0;

		if (closed_s1) begin
			result.emit    = 1'b1;
			result.outcome = OUT_CLOSED;
		end else if (seen_q >= limit) begin
			result.emit    = 1'b1;
			result.outcome = OUT_TOO_LONG;
		end else if (phase_q == PH_HEADER && recent_q == HDR_END_TAIL && b == CH_LF) begin
			result.emit           = 1'b1;
			result.outcome        = OUT_DONE;
			result.length_known   = (lphase_q != LP_NONE);
			result.content_length = (lphase_q != LP_NONE) ? len_out : '0;
		end else begin
			seen_d   = seen_q + LIMIT_W'(1);
			recent_d = {recent_q[15:0], b};
			if (phase_q == PH_HEADER) begin
				// Header lines: find the key, then read its value
				case (lphase_q)
					LP_DIGITS: begin
						if (is_digit(b)) length_d = length_next;
						else lphase_d = LP_DONE;
					end
					LP_SPACE: begin
						if (is_digit(b)) begin
							length_d = length_next;
							lphase_d = LP_DIGITS;
						end else if (b != CH_SPACE && b != CH_TAB) begin
							lphase_d = LP_DONE;
						end
					end
					LP_NONE: begin
						if (match_q < KEY_LEN && b == key_char(match_q)) begin
							match_d = match_q + 4'd1;
						end else begin
							match_d = (b == key_char(4'd0)) ? 4'd1 : 4'd0;
						end
						if (match_d >= KEY_LEN) begin
							match_d  = 4'd0;
							lphase_d = LP_SPACE;
						end
					end
					default: begin
					end
				endcase
			end else if (recent_q[7:0] == CH_CR && b == CH_LF) begin
				phase_d = PH_HEADER;
			end else begin
				// Status line: skip token, read code
				case (phase_q)
					PH_LEAD:   if (!is_white(b)) phase_d = PH_TOKEN;
					PH_TOKEN:  if (is_white(b)) phase_d = PH_GAP;
					PH_GAP: begin
						if (is_digit(b)) begin
							status_d = status_next;
							phase_d  = PH_DIGITS;
						end else if (!is_white(b)) begin
							phase_d = PH_REST;
						end
					end
					PH_DIGITS: begin
						if (is_digit(b)) status_d = status_next;
						else phase_d = PH_REST;
					end
					default: begin
					end
				endcase
			end
		end

		// Clear for the next response
		if (result.emit) begin
			phase_d  = PH_LEAD;
			recent_d = '0;
			status_d = '0;
			match_d  = '0;
			lphase_d = LP_NONE;
			length_d = '0;
			seen_d   = '0;
		end
	end

	// Hold state unless a beat advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			recent_q <= '0;
			status_q <= '0;
			match_q  <= '0;
			lphase_q <= LP_NONE;
			length_q <= '0;
			seen_q   <= '0;
		end else if (beat_fire) begin
			phase_q  <= phase_d;
			recent_q <= recent_d;
			status_q <= status_d;
			match_q  <= match_d;
			lphase_q <= lphase_d;
			length_q <= length_d;
			seen_q   <= seen_d;
		end
	end

endmodule

@@ rtl/http_response_header_parser.sv @@
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-wide HTTP response header parser: status code, Content-Length and an
// outcome per response.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    data_byte[7:0], closed
// out      out  out_valid/out_ready  status_code[15:0], content_length[30:0],
//                                    length_known, outcome[1:0]
// cfg      in   cfg_wr_en            cfg_wr_data[15:0] (header_byte_limit)
//
// One byte per cycle sustained. A beat is taken into the input register; as it
// leaves that register, the parse state and, for a beat that ends a response,
// the output register update together, so a result is offered from the output
// register. The input stalls only when a beat that ends a response meets a
// full output register that is not being taken.
// Reset clears the parse state and sets the byte limit to 1024.
// ----------------------------------------------------------------------------
module http_response_header_parser
	import hrp_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 closed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status_code,
	output logic [OUT_LEN_W-1:0] content_length,
	output logic                 length_known,
	output logic [1:0]           outcome,
	input  logic                 cfg_wr_en,
	input  logic [LIMIT_W-1:0]   cfg_wr_data
);

	logic [LIMIT_W-1:0] limit_q;
	logic               valid_s1;
	logic [7:0]         data_byte_s1;
	logic               closed_s1;
	logic               beat_fire;
	hrp_result_t        result;
	logic               out_valid_q;
	hrp_result_t        out_q;

	// Byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Advance the input register unless its result cannot be stored
	assign beat_fire = valid_s1 && (!result.emit || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || beat_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= data_byte;
			closed_s1    <= closed;
		end
	end

	hrp_parse_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_fire    (beat_fire),
		.data_byte_s1 (data_byte_s1),
		.closed_s1    (closed_s1),
		.limit        (limit_q),
		.result       (result)
	);

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat_fire && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_fire && result.emit) begin
			out_q <= result;
		end
	end

	assign out_valid      = out_valid_q;
	assign status_code    = out_q.status_code;
	assign content_length = out_q.content_length;
	assign length_known   = out_q.length_known;
	assign outcome        = out_q.outcome;

`ifndef ASSERT_OFF
	// A stall means both registers hold a beat
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a full pipeline");

	// An accepted beat lands in the input register
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost");

	// A known length only comes with a complete header
	a_known_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && length_known) |-> (outcome == OUT_DONE))
		else $error("length known on an aborted response");

	// Aborted responses carry no length
	a_abort_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && outcome != OUT_DONE) |-> (content_length == '0))
		else $error("length reported on an aborted response");
`endif

endmodule

@@ dv/http_response_header_parser_tb.sv @@
// ----------------------------------------------------------------------------
// http_response_header_parser_tb
// Streams HTTP response bytes and connection closes into the parser, keeps a
// running model of the status, Content-Length and end-of-header scan, and
// checks every summary the parser returns against the model, in order.
// Covers byte-limit settings from 16 to 65535 with random gaps and stalls.
// ----------------------------------------------------------------------------
module http_response_header_parser_tb;
	import hrp_pkg::*;

	localparam int          WATCHDOG_CYCLES = 1000;
	localparam int          SETTLE_CYCLES   = 8;
	localparam logic [7:0]  CH_VT           = 8'h0B;
	localparam logic [7:0]  CH_FF           = 8'h0C;
	localparam logic [63:0] LEN_CAP         = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
	localparam logic [63:0] OUT_LEN_CAP     = (64'd1 << OUT_LEN_W) - 64'd1;
	localparam logic [8*15-1:0] KEY_TEXT    = "Content-Length:";

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [OUT_LEN_W-1:0] length;
		logic                 known;
		outcome_t             outcome;
	} hdr_summary_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           data_byte;
	logic                 closed;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status_code;
	logic [OUT_LEN_W-1:0] content_length;
	logic                 length_known;
	logic [1:0]           outcome;
	logic                 cfg_wr_en;
	logic [LIMIT_W-1:0]   cfg_wr_data;

	// Parse state mirrored from the incoming beats
	phase_t        ph;
	logic [23:0]   tail;
	logic [15:0]   code_acc;
	logic [3:0]    key_pos;
	len_phase_t    lph;
	logic [63:0]   len_acc;
	logic [15:0]   nbytes;
	logic [15:0]   byte_limit;

	hdr_summary_t  summary_q[$];
	logic [7:0]    resp_bytes[$];
	int unsigned   beats_sent;
	int unsigned   summaries_made;
	int unsigned   mismatches;
	int unsigned   burst_left;
	int unsigned   idle_cycles;
	bit [7:0]      ready_tick;
	bit [1:0]      ready_mode;

	http_response_header_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.closed         (closed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status_code    (status_code),
		.content_length (content_length),
		.length_known   (length_known),
		.outcome        (outcome),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Header scan model
	// ------------------------------------------------------------------
	function automatic logic [7:0] key_at(input logic [3:0] pos);
		return KEY_TEXT[8*(14-pos) +: 8];
	endfunction

	function automatic bit num_char(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic bit blank_char(input logic [7:0] b);
		case (b)
			CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void clear_scan();
		ph       = PH_LEAD;
		tail     = '0;
		code_acc = '0;
		key_pos  = '0;
		lph      = LP_NONE;
		len_acc  = '0;
		nbytes   = '0;
	endfunction

	// Queue the summary of the response in progress and start a fresh one
	function automatic void close_response(input outcome_t oc);
		hdr_summary_t s;
		s.known   = (oc == OUT_DONE) && (lph != LP_NONE);
		s.length  = s.known ? ((len_acc > OUT_LEN_CAP) ? OUT_LEN_CAP[OUT_LEN_W-1:0]
			: len_acc[OUT_LEN_W-1:0]) : '0;
		s.status  = (ph == PH_HEADER) ? code_acc : '0;
		s.outcome = oc;
		summary_q.push_back(s);
		summaries_made++;
		clear_scan();
	endfunction

	function automatic void add_code_digit(input logic [7:0] b);
		logic [31:0] v;
		v = code_acc * 32'd10 + 32'(b - CH_ZERO);
		code_acc = (v > 32'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic void add_len_digit(input logic [7:0] b);
		logic [63:0] d;
		d = 64'(b - CH_ZERO);
		if (len_acc > (LEN_CAP - d) / 64'd10)
			len_acc = LEN_CAP;
		else
			len_acc = len_acc * 64'd10 + d;
	endfunction

	function automatic void scan_status(input logic [7:0] b);
		if (tail[7:0] == CH_CR && b == CH_LF) begin
			ph = PH_HEADER;
		end else begin
			case (ph)
				PH_LEAD: if (!blank_char(b)) ph = PH_TOKEN;
				PH_TOKEN: if (blank_char(b)) ph = PH_GAP;
				PH_GAP: begin
					if (num_char(b)) begin
						add_code_digit(b);
						ph = PH_DIGITS;
					end else if (!blank_char(b)) begin
						ph = PH_REST;
					end
				end
				PH_DIGITS: begin
					if (num_char(b)) add_code_digit(b);
					else ph = PH_REST;
				end
				default: ;
			endcase
		end
	endfunction

	function automatic void scan_header(input logic [7:0] b);
		case (lph)
			LP_DIGITS: begin
				if (num_char(b)) add_len_digit(b);
				else lph = LP_DONE;
			end
			LP_SPACE: begin
				if (num_char(b)) begin
					add_len_digit(b);
					lph = LP_DIGITS;
				end else if (b != CH_SPACE && b != CH_TAB) begin
					lph = LP_DONE;
				end
			end
			LP_NONE: begin
				if (key_pos < KEY_LEN && b == key_at(key_pos))
					key_pos = key_pos + 4'd1;
				else
					key_pos = (b == key_at(4'd0)) ? 4'd1 : 4'd0;
				if (key_pos >= KEY_LEN) begin
					key_pos = '0;
					lph     = LP_SPACE;
				end
			end
			default: ;
		endcase
	endfunction

	// Advance the model by one accepted beat
	function automatic void parse_beat(input logic [7:0] b, input logic cl);
		if (cl) begin
			close_response(OUT_CLOSED);
			return;
		end
		if (nbytes >= byte_limit) begin
			close_response(OUT_TOO_LONG);
			return;
		end
		nbytes = nbytes + 16'd1;
		if (ph == PH_HEADER) begin
			scan_header(b);
			if (tail == HDR_END_TAIL && b == CH_LF) begin
				close_response(OUT_DONE);
				return;
			end
		end else begin
			scan_status(b);
		end
		tail = {tail[15:0], b};
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [7:0] b, input logic cl);
		int unsigned gap;
		// open a new burst, maybe after an idle gap
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= b;
		closed    <= cl;
		do @(posedge clk); while (!in_ready);
		parse_beat(b, cl);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	// Hold the input until every summary is back and the pipeline is empty
	task automatic hold_until_drained();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_byte_limit(input logic [LIMIT_W-1:0] v);
		hold_until_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		byte_limit   = v;
	endtask

	// ------------------------------------------------------------------
	// Response text generation
	// ------------------------------------------------------------------
	function automatic void add_byte(input logic [7:0] b);
		resp_bytes.push_back(b);
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			resp_bytes.push_back(s[i]);
	endfunction

	function automatic void add_digits(input int unsigned n);
		repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] pick_printable();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic void add_header_line();
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				// key, optional junk in front, then optional blanks and a value
				case ($urandom_range(0, 5))
					0: add_str("X-");
					1: add_str("C");
					2: add_str("Content-");
					default: ;
				endcase
				add_str("Content-Length:");
				repeat ($urandom_range(0, 2))
					add_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
				case ($urandom_range(0, 5))
					0: add_str("x");
					1: add_digits($urandom_range(10, 14));
					default: add_digits($urandom_range(1, 4));
				endcase
			end
			3: add_str("Content-Len: 5");
			4: add_str("Host: a");
			default: begin
				repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
			end
		endcase
		add_str("\r\n");
	endfunction

	function automatic void build_response();
		resp_bytes.delete();
		repeat ($urandom_range(0, 1)) add_byte(pick_blank());
		case ($urandom_range(0, 2))
			0: add_str("HTTP/1.1");
			1: add_str("HTTP/1.0");
			default: repeat ($urandom_range(1, 3)) add_byte(pick_printable());
		endcase
		// usually blanks and a code follow; else the status line ends right after the first token
		if ($urandom_range(0, 7) != 0) begin
			repeat ($urandom_range(1, 2)) add_byte(pick_blank());
			case ($urandom_range(0, 7))
				0: begin
					add_byte(($urandom_range(0, 1) != 0) ? "-" : "+");
					add_digits(3);
				end
				1: add_digits($urandom_range(5, 7));
				2: add_str("OK");
				default: add_digits(3);
			endcase
			if ($urandom_range(0, 1) != 0) add_str(" OK");
		end
		add_str("\r\n");
		repeat ($urandom_range(0, 2)) add_header_line();
		add_str("\r\n");
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_close_and_edges();
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_short_headers();
		send_text("A 2\r\n\r\n");
		send_text("X -5\r\n\r\n");
		send_text("\r\n\r\n");
	endtask

	task automatic test_traffic(input logic [LIMIT_W-1:0] limit, input int unsigned beats,
		input int unsigned min_summaries);
		int unsigned beat_goal;
		int unsigned summary_goal;
		int unsigned fate;
		int unsigned cut;
		bit          paused;
		set_byte_limit(limit);
		beat_goal    = beats_sent + beats;
		summary_goal = summaries_made + min_summaries;
		paused       = 1'b0;
		while (beats_sent < beat_goal || summaries_made < summary_goal) begin
			build_response();
			fate = $urandom_range(0, 9);
			cut  = (fate < 2) ? $urandom_range(0, resp_bytes.size() - 1) : resp_bytes.size();
			// prepend line noise
			if (fate == 2)
				repeat ($urandom_range(1, 8)) send_beat(8'($urandom_range(0, 255)), 1'b0);
			for (int i = 0; i < cut; i++)
				send_beat(resp_bytes[i], 1'b0);
			// drop the connection mid response
			if (fate < 2)
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			if (!paused && beats_sent + beats / 2 >= beat_goal) begin
				hold_until_drained();
				paused = 1'b1;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%s", msg);
	endfunction

	always @(posedge clk) begin
		hdr_summary_t want;
		if (arst_n && out_valid && out_ready) begin
			if (summary_q.size() == 0) begin
				note_mismatch($sformatf(
					"unexpected beat: status=%0d len=%0d known=%0d outcome=%0d",
					status_code, content_length, length_known, outcome));
			end else begin
				want = summary_q.pop_front();
				if (status_code !== want.status || content_length !== want.length ||
					length_known !== want.known || outcome !== want.outcome) begin
					note_mismatch($sformatf(
						"mismatch: exp status=%0d len=%0d known=%0d outcome=%0d, got %0d %0d %0d %0d",
						want.status, want.length, want.known, want.outcome,
						status_code, content_length, length_known, outcome));
				end
			end
		end
	end

	// Stall the result side in changing patterns
	always @(posedge clk) begin
		ready_tick <= ready_tick + 8'd1;
		if (ready_tick[5:0] == 6'd0) ready_mode <= 2'($urandom_range(0, 3));
		case (ready_mode)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= (ready_tick[1:0] == 2'd0);
			default: out_ready <= ready_tick[3];
		endcase
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		closed      <= 1'b0;
		out_ready   <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		beats_sent     = 0;
		summaries_made = 0;
		mismatches     = 0;
		burst_left     = 0;
		idle_cycles    = 0;
		byte_limit     = LIMIT_RESET;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_close_and_edges();
		test_short_headers();
		test_traffic(16'd65535, 180, 4);
		test_traffic(16'd16, 130, 4);
		test_traffic(16'($urandom_range(40, 120)), 130, 4);
		test_traffic(LIMIT_RESET, 280, 8);

		hold_until_drained();
		if (mismatches == 0 && summary_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
